// ===== hw/rtl/atpf_pkg.sv =====
// Package for the attitude to PPM frame block: constants, register indexes,
// axis codes and the command and status structs between controller and datapath.
// Used by every module of the block; depends on nothing.
package atpf_pkg;

    // Channel store and pulse constants.
    localparam int STORE_DEPTH = 8;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int WIDTH_W     = 12;
    localparam int SUM_W       = $clog2(STORE_DEPTH * (2 ** WIDTH_W));
    localparam int GAP_W       = 14;
    localparam int SLOT_W      = 4;
    localparam int CFG_W       = 9;
    localparam int CFG_AW      = 3;

    localparam int CHANNELS_DEFAULT = 8;
    localparam int FRAME_US_DEFAULT = 10000;

    localparam logic [WIDTH_W-1:0] PULSE_MID = 12'd1500;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX = 12'd4095;

    // Mapping arithmetic widths: signed angle, divider operands, signed result.
    localparam int ANG_W = 12;
    localparam int MAG_W = 11;
    localparam int DVD_W = MAG_W + 10;
    localparam int DVS_W = 9;
    localparam int VAL_W = DVD_W + 2;

    localparam logic signed [VAL_W-1:0] PULSE_LOW_S  = 23'sd988;
    localparam logic signed [VAL_W-1:0] PULSE_HIGH_S = 23'sd2012;
    localparam logic signed [VAL_W-1:0] WIDTH_MAX_S  = 23'sd4095;

    // Yaw wrap modes and their half spans.
    localparam logic [CFG_W-1:0]        WRAP_360 = 9'd360;
    localparam logic [CFG_W-1:0]        WRAP_270 = 9'd270;
    localparam logic [CFG_W-1:0]        WRAP_180 = 9'd180;
    localparam logic signed [ANG_W-1:0] SPAN_360 = 12'sd360;
    localparam logic signed [ANG_W-1:0] SPAN_270 = 12'sd270;
    localparam logic signed [ANG_W-1:0] SPAN_180 = 12'sd180;
    localparam logic signed [ANG_W-1:0] HALF_360 = 12'sd180;
    localparam logic signed [ANG_W-1:0] HALF_270 = 12'sd135;
    localparam logic signed [ANG_W-1:0] HALF_180 = 12'sd90;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] REG_YAW_RANGE    = 3'd0;
    localparam logic [CFG_AW-1:0] REG_PITCH_RANGE  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_ROLL_RANGE   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_YAW_TRIM     = 3'd3;
    localparam logic [CFG_AW-1:0] REG_PITCH_TRIM   = 3'd4;
    localparam logic [CFG_AW-1:0] REG_ROLL_TRIM    = 3'd5;
    localparam logic [CFG_AW-1:0] REG_SLOT_ASSIGN  = 3'd6;
    localparam logic [CFG_AW-1:0] REG_REVERSE_MASK = 3'd7;

    localparam logic [CFG_W-1:0] RST_YAW_RANGE   = 9'd360;
    localparam logic [CFG_W-1:0] RST_PITCH_RANGE = 9'd180;
    localparam logic [CFG_W-1:0] RST_ROLL_RANGE  = 9'd180;
    localparam logic [CFG_W-1:0] RST_SLOT_ASSIGN = 9'd136;

    // Axis codes, in the order the channel store is written.
    localparam logic [1:0] AXIS_YAW   = 2'd0;
    localparam logic [1:0] AXIS_PITCH = 2'd1;
    localparam logic [1:0] AXIS_ROLL  = 2'd2;

    typedef struct packed {
        logic              load;
        logic              div_start;
        logic              write;
        logic              emit;
        logic [1:0]        axis;
        logic [SLOT_W-1:0] eidx;
    } cmd_t;

    typedef struct packed {
        logic usb;
        logic link;
        logic div_busy;
        logic out_free;
    } status_t;

endpackage

// ===== hw/rtl/attitude_to_ppm_frame.sv =====
// Top level of the attitude to PPM frame block.
// Depends on atpf_pkg, atpf_ctrl and atpf_dpath.
//
// Usage: one head-attitude item enters on the in channel (in_valid, in_stall);
// the block maps yaw, pitch and roll onto pulse widths, writes them into their
// assigned slots of the channel store and sends the frame as CHANNELS+2 items
// on the out channel (out_valid, out_stall): the start mark, one gap per
// channel and the sync gap, which carries last.
// An item with usb_mounted set gives no output; the controller goes from its
// check state straight back to idle. With the link down the three slots take
// 1500 without division. With the link up each axis runs in turn through the
// shared one-bit-per-cycle divider; the frame is emitted once all three slots
// are written, and no new item is taken before the frame is through.
// in_stall is high from acceptance until the last result has been loaded
// into the output register. A stall on the out channel holds the current
// result and pauses the emission; it does not lose or repeat any item.
// Reset clears the configuration to its defaults and the channel store to zero.
// Configuration writes are taken at any cycle with cfg_we high.
module attitude_to_ppm_frame #(
    parameter int CHANNELS = atpf_pkg::CHANNELS_DEFAULT,
    parameter int FRAME_US = atpf_pkg::FRAME_US_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [atpf_pkg::CFG_AW-1:0]  cfg_index,
    input  logic [atpf_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         usb_mounted,
    input  logic                         link_up,
    input  logic signed [9:0]            yaw_deg,
    input  logic signed [8:0]            pitch_deg,
    input  logic signed [8:0]            roll_deg,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [atpf_pkg::SLOT_W-1:0]  slot,
    output logic [atpf_pkg::GAP_W-1:0]   gap_us,
    output logic                         last
);

    atpf_pkg::cmd_t    cmd;
    atpf_pkg::status_t st;

    atpf_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st_i     (st),
        .cmd_o    (cmd)
    );

    atpf_dpath #(
        .CHANNELS (CHANNELS),
        .FRAME_US (FRAME_US)
    ) u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .usb_mounted (usb_mounted),
        .link_up     (link_up),
        .yaw_deg     (yaw_deg),
        .pitch_deg   (pitch_deg),
        .roll_deg    (roll_deg),
        .cmd_i       (cmd),
        .st_o        (st),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .slot        (slot),
        .gap_us      (gap_us),
        .last        (last)
    );

endmodule

// ===== hw/rtl/atpf_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the three axes.
// Depends on atpf_pkg for operand widths.
module atpf_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [atpf_pkg::DVD_W-1:0] dividend,
    input  logic [atpf_pkg::DVS_W-1:0] divisor,
    output logic                       busy,
    output logic [atpf_pkg::DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(atpf_pkg::DVD_W + 1);

    logic                       busy_reg;
    logic                       busy_next;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;
    logic [atpf_pkg::DVS_W-1:0] rem_reg;
    logic [atpf_pkg::DVS_W-1:0] rem_next;
    logic [atpf_pkg::DVD_W-1:0] quo_reg;
    logic [atpf_pkg::DVD_W-1:0] quo_next;
    logic [atpf_pkg::DVS_W-1:0] dvs_reg;
    logic [atpf_pkg::DVS_W-1:0] dvs_next;
    logic [atpf_pkg::DVS_W:0]   trial;
    logic [atpf_pkg::DVS_W:0]   diff;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        // The dividend shifts out of the top of quo_reg while quotient bits enter below.
        trial = {rem_reg, quo_reg[atpf_pkg::DVD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(atpf_pkg::DVD_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[atpf_pkg::DVS_W-1:0];
                quo_next = {quo_reg[atpf_pkg::DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[atpf_pkg::DVS_W-1:0];
                quo_next = {quo_reg[atpf_pkg::DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/atpf_dpath.sv =====
// Datapath: configuration registers, item registers, axis mapping around the
// shared divider, the channel store, the frame sum and the output register.
// Depends on atpf_pkg and atpf_div.
module atpf_dpath #(
    parameter int CHANNELS = atpf_pkg::CHANNELS_DEFAULT,
    parameter int FRAME_US = atpf_pkg::FRAME_US_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [atpf_pkg::CFG_AW-1:0]       cfg_index,
    input  logic [atpf_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              usb_mounted,
    input  logic                              link_up,
    input  logic signed [9:0]                 yaw_deg,
    input  logic signed [8:0]                 pitch_deg,
    input  logic signed [8:0]                 roll_deg,
    input  atpf_pkg::cmd_t                    cmd_i,
    output atpf_pkg::status_t                 st_o,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [atpf_pkg::SLOT_W-1:0]       slot,
    output logic [atpf_pkg::GAP_W-1:0]        gap_us,
    output logic                              last
);

    localparam int ANG_W = atpf_pkg::ANG_W;
    localparam int VAL_W = atpf_pkg::VAL_W;
    localparam int WW    = atpf_pkg::WIDTH_W;

    // Configuration registers.
    logic [atpf_pkg::CFG_W-1:0] yaw_range_reg;
    logic [atpf_pkg::CFG_W-1:0] pitch_range_reg;
    logic [atpf_pkg::CFG_W-1:0] roll_range_reg;
    logic [atpf_pkg::CFG_W-1:0] yaw_trim_reg;
    logic [atpf_pkg::CFG_W-1:0] pitch_trim_reg;
    logic [atpf_pkg::CFG_W-1:0] roll_trim_reg;
    logic [atpf_pkg::CFG_W-1:0] slot_assign_reg;
    logic [2:0]                 reverse_mask_reg;

    // Latched item.
    logic              usb_reg;
    logic              link_reg;
    logic signed [9:0] yaw_reg;
    logic signed [8:0] pitch_reg;
    logic signed [8:0] roll_reg;

    logic [WW-1:0]                   width_reg [atpf_pkg::STORE_DEPTH];
    logic [atpf_pkg::SUM_W-1:0]      sum_reg;
    logic [atpf_pkg::SUM_W-1:0]      sum_next;
    logic                            out_valid_reg;
    logic [atpf_pkg::SLOT_W-1:0]     slot_reg;
    logic [atpf_pkg::GAP_W-1:0]      gap_reg;
    logic                            last_reg;
    logic [atpf_pkg::GAP_W-1:0]      gap_next;
    logic                            last_next;

    logic signed [ANG_W-1:0]     yaw_ext;
    logic signed [ANG_W-1:0]     yaw_wrapped;
    logic signed [ANG_W-1:0]     ang;
    logic signed [ANG_W-1:0]     trim;
    logic signed [ANG_W-1:0]     half;
    logic signed [ANG_W-1:0]     t_val;
    logic [ANG_W-1:0]            t_abs;
    logic [atpf_pkg::CFG_W-1:0]  range_sel;
    logic                        rev;
    logic [2:0]                  wslot;
    logic                        res_neg;
    logic [atpf_pkg::DVD_W-1:0]  dividend;
    logic [atpf_pkg::DVS_W-1:0]  divisor;
    logic                        div_busy;
    logic [atpf_pkg::DVD_W-1:0]  quotient;
    logic signed [VAL_W-1:0]     q_signed;
    logic signed [VAL_W-1:0]     mapped;
    logic [WW-1:0]               wval;
    logic [atpf_pkg::STORE_AW-1:0] ridx;
    logic [atpf_pkg::SLOT_W-1:0]   eidx_m1;
    logic [atpf_pkg::SUM_W-1:0]    frame_sum;

    assign frame_sum = atpf_pkg::SUM_W'(FRAME_US);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_range_reg    <= atpf_pkg::RST_YAW_RANGE;
            pitch_range_reg  <= atpf_pkg::RST_PITCH_RANGE;
            roll_range_reg   <= atpf_pkg::RST_ROLL_RANGE;
            yaw_trim_reg     <= '0;
            pitch_trim_reg   <= '0;
            roll_trim_reg    <= '0;
            slot_assign_reg  <= atpf_pkg::RST_SLOT_ASSIGN;
            reverse_mask_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                atpf_pkg::REG_YAW_RANGE:    yaw_range_reg    <= cfg_data;
                atpf_pkg::REG_PITCH_RANGE:  pitch_range_reg  <= cfg_data;
                atpf_pkg::REG_ROLL_RANGE:   roll_range_reg   <= cfg_data;
                atpf_pkg::REG_YAW_TRIM:     yaw_trim_reg     <= cfg_data;
                atpf_pkg::REG_PITCH_TRIM:   pitch_trim_reg   <= cfg_data;
                atpf_pkg::REG_ROLL_TRIM:    roll_trim_reg    <= cfg_data;
                atpf_pkg::REG_SLOT_ASSIGN:  slot_assign_reg  <= cfg_data;
                atpf_pkg::REG_REVERSE_MASK: reverse_mask_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_i.load)
        begin
            usb_reg   <= usb_mounted;
            link_reg  <= link_up;
            yaw_reg   <= yaw_deg;
            pitch_reg <= pitch_deg;
            roll_reg  <= roll_deg;
        end
    end

    // Axis operand selection and the divider's operands.
    always_comb
    begin
        yaw_ext = ANG_W'(yaw_reg);
        yaw_wrapped = yaw_ext;
        if (yaw_range_reg == atpf_pkg::WRAP_360 && yaw_ext > atpf_pkg::HALF_360)
        begin
            yaw_wrapped = yaw_ext - atpf_pkg::SPAN_360;
        end
        else if (yaw_range_reg == atpf_pkg::WRAP_270 && yaw_ext > atpf_pkg::HALF_270)
        begin
            yaw_wrapped = yaw_ext - atpf_pkg::SPAN_270;
        end
        else if (yaw_range_reg == atpf_pkg::WRAP_180 && yaw_ext > atpf_pkg::HALF_180)
        begin
            yaw_wrapped = yaw_ext - atpf_pkg::SPAN_180;
        end

        unique case (cmd_i.axis)
            atpf_pkg::AXIS_YAW:
            begin
                ang       = yaw_wrapped;
                trim      = ANG_W'($signed(yaw_trim_reg));
                range_sel = yaw_range_reg;
                rev       = reverse_mask_reg[0];
                wslot     = slot_assign_reg[2:0];
            end
            atpf_pkg::AXIS_PITCH:
            begin
                ang       = ANG_W'(pitch_reg);
                trim      = ANG_W'($signed(pitch_trim_reg));
                range_sel = pitch_range_reg;
                rev       = reverse_mask_reg[1];
                wslot     = slot_assign_reg[5:3];
            end
            atpf_pkg::AXIS_ROLL:
            begin
                ang       = ANG_W'(roll_reg);
                trim      = ANG_W'($signed(roll_trim_reg));
                range_sel = roll_range_reg;
                rev       = reverse_mask_reg[2];
                wslot     = slot_assign_reg[8:6];
            end
            default:
            begin
                ang       = '0;
                trim      = '0;
                range_sel = '0;
                rev       = 1'b0;
                wslot     = '0;
            end
        endcase

        half     = $signed({{(ANG_W - atpf_pkg::CFG_W + 1){1'b0}},
                             range_sel[atpf_pkg::CFG_W-1:1]});
        t_val    = ang + trim + half;
        t_abs    = t_val[ANG_W-1] ? ANG_W'(-t_val) : ANG_W'(t_val);
        // The pulse rise is 1024, so the product is the magnitude shifted by ten.
        dividend = {t_abs[atpf_pkg::MAG_W-1:0], 10'd0};
        divisor  = {range_sel[atpf_pkg::CFG_W-1:1], 1'b0};
        res_neg  = t_val[ANG_W-1] ^ rev;
    end

    atpf_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd_i.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // Sign, offset and saturation of the quotient.
    always_comb
    begin
        q_signed = res_neg ? -$signed({2'b00, quotient}) : $signed({2'b00, quotient});
        mapped   = q_signed + (rev ? atpf_pkg::PULSE_HIGH_S : atpf_pkg::PULSE_LOW_S);
        if (!link_reg)
        begin
            wval = atpf_pkg::PULSE_MID;
        end
        else if (range_sel[atpf_pkg::CFG_W-1:1] == '0)
        begin
            // An empty range saturates the width to zero.
            wval = '0;
        end
        else if (mapped[VAL_W-1])
        begin
            wval = '0;
        end
        else if (mapped > atpf_pkg::WIDTH_MAX_S)
        begin
            wval = atpf_pkg::WIDTH_MAX;
        end
        else
        begin
            wval = mapped[WW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < atpf_pkg::STORE_DEPTH; i++)
            begin
                width_reg[i] <= '0;
            end
        end
        else if (cmd_i.write && ({1'b0, wslot} < atpf_pkg::SLOT_W'(CHANNELS)))
        begin
            width_reg[wslot] <= wval;
        end
    end

    // Frame emission: start mark, channel gaps, then the sync gap.
    always_comb
    begin
        eidx_m1   = cmd_i.eidx - 1'b1;
        ridx      = eidx_m1[atpf_pkg::STORE_AW-1:0];
        sum_next  = sum_reg;
        gap_next  = '0;
        last_next = 1'b0;
        if (cmd_i.eidx == '0)
        begin
            sum_next = '0;
        end
        else if (cmd_i.eidx <= atpf_pkg::SLOT_W'(CHANNELS))
        begin
            gap_next = atpf_pkg::GAP_W'(width_reg[ridx]);
            sum_next = sum_reg + atpf_pkg::SUM_W'(width_reg[ridx]);
        end
        else
        begin
            last_next = 1'b1;
            if (sum_reg < frame_sum)
            begin
                gap_next = atpf_pkg::GAP_W'(frame_sum - sum_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd_i.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_i.emit)
        begin
            sum_reg  <= sum_next;
            slot_reg <= cmd_i.eidx;
            gap_reg  <= gap_next;
            last_reg <= last_next;
        end
    end

    assign st_o.usb      = usb_reg;
    assign st_o.link     = link_reg;
    assign st_o.div_busy = div_busy;
    assign st_o.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign slot      = slot_reg;
    assign gap_us    = gap_reg;
    assign last      = last_reg;

endmodule

// ===== hw/rtl/atpf_ctrl.sv =====
// Controller: sequences the item through three axis mappings and the frame emission.
// Depends on atpf_pkg for the command and status structs.
module atpf_ctrl #(
    parameter int CHANNELS = atpf_pkg::CHANNELS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  atpf_pkg::status_t st_i,
    output atpf_pkg::cmd_t    cmd_o
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_START,
        S_DIV,
        S_WRITE,
        S_EMIT
    } state_t;

    localparam logic [atpf_pkg::SLOT_W-1:0] EIDX_LAST = atpf_pkg::SLOT_W'(CHANNELS + 1);

    state_t                      state_reg;
    state_t                      state_next;
    logic [1:0]                  axis_reg;
    logic [1:0]                  axis_next;
    logic [atpf_pkg::SLOT_W-1:0] eidx_reg;
    logic [atpf_pkg::SLOT_W-1:0] eidx_next;

    always_comb
    begin
        state_next      = state_reg;
        axis_next       = axis_reg;
        eidx_next       = eidx_reg;
        cmd_o.load      = 1'b0;
        cmd_o.div_start = 1'b0;
        cmd_o.write     = 1'b0;
        cmd_o.emit      = 1'b0;
        cmd_o.axis      = axis_reg;
        cmd_o.eidx      = eidx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_o.load = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                axis_next = atpf_pkg::AXIS_YAW;
                eidx_next = '0;
                if (st_i.usb)
                begin
                    state_next = S_IDLE;
                end
                else if (st_i.link)
                begin
                    state_next = S_START;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_START:
            begin
                cmd_o.div_start = 1'b1;
                state_next      = S_DIV;
            end
            S_DIV:
            begin
                if (!st_i.div_busy)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd_o.write = 1'b1;
                if (axis_reg == atpf_pkg::AXIS_ROLL)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = st_i.link ? S_START : S_WRITE;
                end
            end
            S_EMIT:
            begin
                if (st_i.out_free)
                begin
                    cmd_o.emit = 1'b1;
                    eidx_next  = eidx_reg + 1'b1;
                    if (eidx_reg == EIDX_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= '0;
            eidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            eidx_reg  <= eidx_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // A new division must never restart the divider in the middle of a run.
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_o.div_start |-> !st_i.div_busy)
        else $error("divider restarted while busy");

    // An item is only emitted into a free output register.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_o.emit |-> st_i.out_free)
        else $error("item emitted over an unaccepted result");

    // The axis counter covers yaw, pitch and roll only.
    a_axis_bound: assert property (@(posedge clk) disable iff (!rst_n)
        axis_reg != 2'd3)
        else $error("axis counter out of range");

    // The emission index stops at the sync gap.
    a_eidx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (eidx_reg <= EIDX_LAST))
        else $error("emission index beyond the sync gap");

    // The store is written only after the divider has finished.
    a_write_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_o.write |-> !st_i.div_busy)
        else $error("channel written while the divider is busy");

endmodule
